### rtl/core/asp_pkg.sv
// shared types and character codes for the add/subtract/parenthesis evaluator
package asp_pkg;

	// ascii codes recognized by the evaluator
	localparam logic [7:0] CHAR_ZERO   = 8'h30;
	localparam logic [7:0] CHAR_NINE   = 8'h39;
	localparam logic [7:0] CHAR_LPAREN = 8'h28;
	localparam logic [7:0] CHAR_RPAREN = 8'h29;
	localparam logic [7:0] CHAR_PLUS   = 8'h2B;
	localparam logic [7:0] CHAR_MINUS  = 8'h2D;

	localparam int unsigned VALUE_W = 32;

	// one saved nesting level: outer sum and the sign in force before '('
	typedef struct packed {
		logic [VALUE_W-1:0] sum;
		logic               neg;
	} asp_entry_t;

endpackage

### rtl/core/asp_char_if.sv
// input channel: one character item with its end-of-expression flag
interface asp_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       last_char;

	modport source (output valid, output char_code, output last_char, input ready);
	modport sink (input valid, input char_code, input last_char, output ready);
endinterface

### rtl/core/asp_result_if.sv
// output channel: evaluated value and error flag
interface asp_result_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] value;
	logic               error;

	modport source (output valid, output value, output error, input ready);
	modport sink (input valid, input value, input error, output ready);
endinterface

### rtl/core/asp_stack.sv
// nesting stack memory: one write port, one registered read port
module asp_stack #(
	parameter int unsigned DEPTH = 32,
	parameter int unsigned AW    = 5
) (
	input  logic                clk,
	input  logic                wr_en,
	input  logic [AW-1:0]       wr_addr,
	input  asp_pkg::asp_entry_t wr_data,
	input  logic                rd_en,
	input  logic [AW-1:0]       rd_addr,
	output asp_pkg::asp_entry_t rd_data
);
	import asp_pkg::*;

	asp_entry_t mem [0:DEPTH-1];
	asp_entry_t rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
endmodule

### rtl/core/add_sub_paren_expression_eval.sv
// Streaming evaluator of decimal +/- expressions with parentheses.
// Throughput: one character item per cycle while no last_char item waits on an untaken earlier result.
// The last_char item is held in the input register, and its result is then loaded into the result register.
// Stack: top entry in flops, the entry below it prefetched from a one-port-write,
//   one-port-read memory so back-to-back ')' items need no wait.
// Reset clears sum, sign, digit accumulator, level, error and valid flags; stack contents are not cleared.
module add_sub_paren_expression_eval #(
	parameter int unsigned NEST_DEPTH = 32
) (
	input logic         clk,
	input logic         arst_n,
	asp_char_if.sink    chars,
	asp_result_if.source results
);
	import asp_pkg::*;

	localparam int unsigned LW = $clog2(NEST_DEPTH + 1);
	localparam int unsigned AW = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;

	// input register
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       last_s1;

	// evaluator state
	logic [VALUE_W-1:0] sum_q;
	logic               neg_q;
	logic [VALUE_W-1:0] acc_q;
	logic [LW-1:0]      level_q;
	logic               err_q;
	asp_entry_t         top_q;
	asp_entry_t         below;

	// result register
	logic               out_valid_q;
	logic [VALUE_W-1:0] out_value_q;
	logic               out_error_q;

	logic go;
	logic slot_free;
	logic in_accept;

	// flow control
	assign slot_free = !out_valid_q || results.ready;
	assign go        = valid_s1 && (!last_s1 || slot_free);
	assign chars.ready = !valid_s1 || go;
	assign in_accept = chars.valid && chars.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			char_s1 <= chars.char_code;
			last_s1 <= chars.last_char;
		end
	end

	// next-state logic
	logic               is_digit;
	logic [3:0]         digit_off;
	logic [VALUE_W-1:0] acc_dig;
	logic [VALUE_W-1:0] fold;
	logic [VALUE_W-1:0] fold_dig;
	logic [VALUE_W-1:0] inner;
	logic [VALUE_W-1:0] n_sum;
	logic               n_neg;
	logic [VALUE_W-1:0] n_acc;
	logic [LW-1:0]      n_level;
	logic               n_err;
	asp_entry_t         n_top;
	logic               push;
	logic [VALUE_W-1:0] res_value;
	logic [AW-1:0]      rd_idx;

	always_comb begin
		is_digit  = (char_s1 >= CHAR_ZERO) && (char_s1 <= CHAR_NINE);
		digit_off = 4'(char_s1 - CHAR_ZERO);
		acc_dig   = {acc_q[VALUE_W-4:0], 3'b000} + {acc_q[VALUE_W-2:0], 1'b0}
			+ {{(VALUE_W-4){1'b0}}, digit_off};
		fold      = neg_q ? (sum_q - acc_q) : (sum_q + acc_q);
		fold_dig  = neg_q ? (sum_q - acc_dig) : (sum_q + acc_dig);
		inner     = top_q.neg ? (VALUE_W'(0) - fold) : fold;

		n_sum   = sum_q;
		n_neg   = neg_q;
		n_acc   = acc_q;
		n_level = level_q;
		n_err   = err_q;
		n_top   = top_q;
		push    = 1'b0;

		if (is_digit) begin
			n_acc = acc_dig;
		end else begin
			n_acc = '0;
			n_sum = fold;
			unique case (char_s1)
				CHAR_LPAREN: begin
					if (level_q < LW'(NEST_DEPTH)) begin
						push      = 1'b1;
						n_level   = level_q + LW'(1);
						n_sum     = '0;
						n_neg     = 1'b0;
						n_top.sum = fold;
						n_top.neg = neg_q;
					end else begin
						n_err = 1'b1;
					end
				end
				CHAR_RPAREN: begin
					if (level_q != '0) begin
						n_level = level_q - LW'(1);
						n_sum   = inner + top_q.sum;
						n_top   = below;
					end else begin
						n_err = 1'b1;
					end
				end
				CHAR_PLUS:  n_neg = 1'b0;
				CHAR_MINUS: n_neg = 1'b1;
				default:    ;
			endcase
		end

		// final fold: only a digit item leaves a pending number
		res_value = is_digit ? fold_dig : n_sum;

		// prefetch the entry below the new top
		rd_idx = AW'(n_level - LW'(2));
	end

	// stack memory
	asp_stack #(
		.DEPTH (NEST_DEPTH),
		.AW    (AW)
	) u_stack (
		.clk     (clk),
		.wr_en   (go && push),
		.wr_addr (level_q[AW-1:0]),
		.wr_data (n_top),
		.rd_en   (go),
		.rd_addr (rd_idx),
		.rd_data (below)
	);

	// state registers, cleared after the last item of an expression
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			neg_q   <= 1'b0;
			acc_q   <= '0;
			level_q <= '0;
			err_q   <= 1'b0;
		end else if (go) begin
			if (last_s1) begin
				sum_q   <= '0;
				neg_q   <= 1'b0;
				acc_q   <= '0;
				level_q <= '0;
				err_q   <= 1'b0;
			end else begin
				sum_q   <= n_sum;
				neg_q   <= n_neg;
				acc_q   <= n_acc;
				level_q <= n_level;
				err_q   <= n_err;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			top_q <= n_top;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && last_s1) begin
			out_value_q <= res_value;
			out_error_q <= n_err;
		end
	end

	assign results.valid = out_valid_q;
	assign results.value = out_value_q;
	assign results.error = out_error_q;
endmodule

### rtl/core/asp_checker.sv
// port-level checks for the expression evaluator, bound to the top level
module asp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] out_value,
	input logic        out_error
);
	// a stalled result holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_error))
		else $error("result changed while stalled");

	// input stalls only when a finished result is waiting downstream
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without a pending result");

	// no result is shown after a reset edge
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("result valid during reset");

	// a fresh result needs an input item that was accepted and passed through the input register
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result appeared without an input item");
endmodule

bind add_sub_paren_expression_eval asp_checker u_asp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (chars.valid),
	.in_ready  (chars.ready),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.out_value (results.value),
	.out_error (results.error)
);
